FILE: hw/rtl/sat_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the shell argument tokenizer.
// No dependencies; sat_front, sat_back and the top level import this package, sat_fifo does not.
package sat_pkg;

   // character codes the parser reacts to
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   // queue depths between the parts
   localparam int TOK_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 2;

   // parser mode
   typedef enum logic [1:0] {
      MODE_BETWEEN,
      MODE_PLAIN,
      MODE_ESCAPE,
      MODE_QUOTED
   } mode_type;

   // classified input character, front to back
   typedef struct packed {
      logic [7:0] data;
      logic       is_nul;
      logic       is_last;
      logic       is_space;
      logic       is_dquote;
      logic       is_squote;
      logic       is_bslash;
   } tok_type;

   // one result word
   typedef struct packed {
      logic       has_byte;
      logic [7:0] out_byte;
      logic       ends_arg;
      logic [3:0] arg_index;
      logic       string_done;
      logic [3:0] arg_total;
   } rsp_type;

endpackage

FILE: hw/rtl/shell_argument_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the shell argument tokenizer: front, token queue, parser, result queue.
// Depends on sat_pkg, sat_front, sat_fifo and sat_back.
//
//   channel  ports                          direction  handshake
//   request  req_in_byte, req_is_last       in         req_push / req_full
//   response rsp_has_byte .. rsp_arg_total  out        rsp_pop / rsp_empty
//
// While no queue is full, one character per clock; the parser pops one character per cycle.
// Characters are registered in the front stage and token queue, results in the result queue.
// Spare separators, opening quotes and escape marks give no result; they only update state.
// Reset is synchronous and clears queues and parser state; there is no clearing pass.
// A stalled result side fills the result queue, then the token queue, then raises req_full.
module shell_argument_tokenizer #(
   parameter int MAX_ARGS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_last,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_has_byte,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_ends_arg,
   output logic [3:0] rsp_arg_index,
   output logic       rsp_string_done,
   output logic [3:0] rsp_arg_total
);
   import sat_pkg::*;

   logic    front_valid, front_ready;
   tok_type front_tok, head_tok;
   logic    tok_full, tok_empty, tok_pop;
   logic    rsp_full, back_push;
   rsp_type back_rsp, head_rsp;

   sat_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .req_is_last (req_is_last),
      .req_full    (req_full),
      .tok_valid   (front_valid),
      .tok         (front_tok),
      .tok_ready   (front_ready)
   );

   assign front_ready = !tok_full;

   // classified characters waiting for the parser
   sat_fifo #(
      .WIDTH ($bits(tok_type)),
      .DEPTH (TOK_QUEUE_DEPTH)
   ) u_tok_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_tok),
      .full      (tok_full),
      .pop       (tok_pop),
      .pop_data  (head_tok),
      .empty     (tok_empty)
   );

   sat_back #(
      .MAX_ARGS (MAX_ARGS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (!tok_empty),
      .tok       (head_tok),
      .tok_pop   (tok_pop),
      .rsp_ready (!rsp_full),
      .rsp_push  (back_push),
      .rsp       (back_rsp)
   );

   // finished result words
   sat_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (head_rsp),
      .empty     (rsp_empty)
   );

   assign rsp_has_byte    = head_rsp.has_byte;
   assign rsp_out_byte    = head_rsp.out_byte;
   assign rsp_ends_arg    = head_rsp.ends_arg;
   assign rsp_arg_index   = head_rsp.arg_index;
   assign rsp_string_done = head_rsp.string_done;
   assign rsp_arg_total   = head_rsp.arg_total;

endmodule

FILE: hw/rtl/sat_fifo.sv
`timescale 1ns / 1ps
// Small register queue used between the tokenizer parts.
// Self-contained; no package needed.
module sat_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/sat_front.sv
`timescale 1ns / 1ps
// Front end: takes input words and classifies each character.
// Depends on sat_pkg (tok_type, character codes).
module sat_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [7:0]       req_in_byte,
   input  logic             req_is_last,
   output logic             req_full,
   output logic             tok_valid,
   output sat_pkg::tok_type tok,
   input  logic             tok_ready
);
   import sat_pkg::*;

   logic    stage_valid_ff, stage_valid_in;
   tok_type stage_ff, stage_in;
   logic    accept;

   assign req_full  = stage_valid_ff && !tok_ready;
   assign accept    = req_push && !req_full;
   assign tok_valid = stage_valid_ff;
   assign tok       = stage_ff;

   // character classes
   always_comb begin
      stage_in.data      = req_in_byte;
      stage_in.is_nul    = (req_in_byte == CHAR_NUL);
      stage_in.is_last   = req_is_last;
      stage_in.is_space  = req_in_byte inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
      stage_in.is_dquote = (req_in_byte == CHAR_DQUOTE);
      stage_in.is_squote = (req_in_byte == CHAR_SQUOTE);
      stage_in.is_bslash = (req_in_byte == CHAR_BSLASH);
   end

   // stage occupancy
   always_comb begin
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (tok_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

FILE: hw/rtl/sat_back.sv
`timescale 1ns / 1ps
// Back end: parse state machine that turns classified characters into results.
// Depends on sat_pkg (mode_type, tok_type, rsp_type).
module sat_back #(
   parameter int MAX_ARGS = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             tok_valid,
   input  sat_pkg::tok_type tok,
   output logic             tok_pop,
   input  logic             rsp_ready,
   output logic             rsp_push,
   output sat_pkg::rsp_type rsp
);
   import sat_pkg::*;

   mode_type   mode_ff, mode_in, mode_mid;
   logic       single_ff, single_in, single_mid;
   logic [3:0] found_ff, found_in, found_mid;
   logic       has, ends_mid, ends_all, last, emit, quote_match;

   assign tok_pop = tok_valid && rsp_ready;

   // character step
   always_comb begin
      mode_mid    = mode_ff;
      single_mid  = single_ff;
      has         = 1'b0;
      ends_mid    = 1'b0;
      quote_match = single_ff ? tok.is_squote : tok.is_dquote;
      if (!tok.is_nul) begin
         case (mode_ff)
            MODE_BETWEEN: begin
               if (found_ff < 4'(MAX_ARGS) && !tok.is_space) begin
                  if (tok.is_dquote || tok.is_squote) begin
                     mode_mid   = MODE_QUOTED;
                     single_mid = tok.is_squote;
                  end else if (tok.is_bslash) begin
                     mode_mid = MODE_ESCAPE;
                  end else begin
                     mode_mid = MODE_PLAIN;
                     has      = 1'b1;
                  end
               end
            end
            MODE_PLAIN: begin
               if (tok.is_space) begin
                  ends_mid = 1'b1;
               end else if (tok.is_bslash) begin
                  mode_mid = MODE_ESCAPE;
               end else begin
                  has = 1'b1;
               end
            end
            MODE_ESCAPE: begin
               mode_mid = MODE_PLAIN;
               has      = 1'b1;
            end
            MODE_QUOTED: begin
               if (quote_match) begin
                  ends_mid = 1'b1;
               end else begin
                  has = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (ends_mid) begin
         mode_mid = MODE_BETWEEN;
      end
      // string end closes any open argument
      last      = tok.is_nul || tok.is_last;
      ends_all  = ends_mid || (last && mode_mid != MODE_BETWEEN);
      found_mid = found_ff + {3'b000, ends_all};
      emit      = has || ends_all || last;
   end

   // next state
   always_comb begin
      mode_in   = mode_ff;
      single_in = single_ff;
      found_in  = found_ff;
      if (tok_pop) begin
         if (last) begin
            mode_in   = MODE_BETWEEN;
            single_in = 1'b0;
            found_in  = '0;
         end else begin
            mode_in   = mode_mid;
            single_in = single_mid;
            found_in  = found_mid;
         end
      end
   end

   // result word
   always_comb begin
      rsp_push        = tok_pop && emit;
      rsp.has_byte    = has;
      rsp.out_byte    = has ? tok.data : '0;
      rsp.ends_arg    = ends_all;
      rsp.arg_index   = (has || ends_all) ? found_ff : '0;
      rsp.string_done = last;
      rsp.arg_total   = last ? found_mid : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_BETWEEN;
         single_ff <= 1'b0;
         found_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         single_ff <= single_in;
         found_ff  <= found_in;
      end
   end

endmodule

FILE: hw/rtl/sat_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the shell argument tokenizer, bound to the top level.
// Depends only on the top level's ports.
module sat_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_has_byte,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_ends_arg,
   input logic [3:0] rsp_arg_index,
   input logic       rsp_string_done,
   input logic [3:0] rsp_arg_total
);

   // a word waiting on the output holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(!rsp_empty && !rsp_pop)
      |-> !rsp_empty && $stable(rsp_out_byte) && $stable(rsp_arg_index))
      else $error("waiting result word changed before pop");

   // the count only shows on the closing word of a string
   a_total_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_string_done |-> rsp_arg_total == 4'd0)
      else $error("arg_total set on a word that does not end the string");

   // a character slot without a character carries zero
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_has_byte |-> rsp_out_byte == 8'd0)
      else $error("out_byte set without has_byte");

   // an argument closed at the string end is the last one counted
   a_close_count: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_string_done && rsp_ends_arg
      |-> rsp_arg_total == rsp_arg_index + 4'd1)
      else $error("closing argument index disagrees with arg_total");

   // index only meaningful on a character or end mark
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_has_byte && !rsp_ends_arg |-> rsp_arg_index == 4'd0)
      else $error("arg_index set on a word with no character and no end mark");

endmodule

bind shell_argument_tokenizer sat_checker u_sat_checker (.*);

FILE: tb/shell_argument_tokenizer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for shell_argument_tokenizer: directed command lines, back-pressure
// and random lines, each result word checked against a cycle-free tokenizer predictor.
// Depends on sat_pkg and the shell_argument_tokenizer RTL.
module shell_argument_tokenizer_test;
   import sat_pkg::*;

   localparam int TB_MAX_ARGS  = 10;
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_CHARS = 1200;
   localparam int IDLE_PCT     = 14;
   localparam int REPORT_MAX   = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_is_last = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_has_byte;
   logic [7:0] rsp_out_byte;
   logic       rsp_ends_arg;
   logic [3:0] rsp_arg_index;
   logic       rsp_string_done;
   logic [3:0] rsp_arg_total;

   // tokenizer state mirrored by the predictor
   mode_type   parse_state = MODE_BETWEEN;
   logic       quote_single = 1'b0;
   logic [3:0] args_closed = 4'd0;

   rsp_type    expected_words[$];
   logic [8:0] line_chars[$];   // {is_last, byte}

   int idle_pct = IDLE_PCT;
   int hold_requests = 0;
   int error_count = 0;
   int cycle_count = 0;
   int chars_sent = 0;
   int words_checked = 0;
   int strings_done = 0;
   int strings_at_limit = 0;
   int input_stalls = 0;

   shell_argument_tokenizer #(.MAX_ARGS(TB_MAX_ARGS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_in_byte    (req_in_byte),
      .req_is_last    (req_is_last),
      .req_full       (req_full),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_ends_arg   (rsp_ends_arg),
      .rsp_arg_index  (rsp_arg_index),
      .rsp_string_done(rsp_string_done),
      .rsp_arg_total  (rsp_arg_total)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
                  expected_words.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic bit is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // advance the tokenizer by one character; returns 1 when a result word is produced
   function automatic bit tokenize_char(input logic [7:0] c, input logic last_in,
                                        output rsp_type word);
      logic       emit, has, ends, done, last;
      logic [7:0] ch;
      logic [3:0] idx;
      emit = 1'b0; has = 1'b0; ends = 1'b0; done = 1'b0;
      last = last_in;
      ch   = 8'h00;
      idx  = args_closed;

      if (c == CHAR_NUL) begin
         last = 1'b1;
      end else begin
         case (parse_state)
            MODE_BETWEEN: begin
               if (args_closed < TB_MAX_ARGS && !is_blank(c)) begin
                  if (c == CHAR_DQUOTE || c == CHAR_SQUOTE) begin
                     parse_state  = MODE_QUOTED;
                     quote_single = (c == CHAR_SQUOTE);
                  end else if (c == CHAR_BSLASH) begin
                     parse_state = MODE_ESCAPE;
                  end else begin
                     parse_state = MODE_PLAIN;
                     emit = 1'b1; has = 1'b1; ch = c;
                  end
               end
            end
            MODE_PLAIN: begin
               if (is_blank(c)) begin
                  emit = 1'b1; ends = 1'b1;
               end else if (c == CHAR_BSLASH) begin
                  parse_state = MODE_ESCAPE;
               end else begin
                  emit = 1'b1; has = 1'b1; ch = c;
               end
            end
            MODE_ESCAPE: begin
               parse_state = MODE_PLAIN;
               emit = 1'b1; has = 1'b1; ch = c;
            end
            default: begin
               // quoted: only the matching quote closes, no escapes
               emit = 1'b1;
               if (c == (quote_single ? CHAR_SQUOTE : CHAR_DQUOTE)) ends = 1'b1;
               else begin
                  has = 1'b1; ch = c;
               end
            end
         endcase
      end

      if (ends) begin
         parse_state = MODE_BETWEEN;
         args_closed = args_closed + 4'd1;
      end

      // string end closes any open argument
      if (last) begin
         if (parse_state != MODE_BETWEEN) begin
            ends = 1'b1;
            parse_state = MODE_BETWEEN;
            args_closed = args_closed + 4'd1;
         end
         emit = 1'b1;
         done = 1'b1;
      end

      word.has_byte    = has;
      word.out_byte    = has ? ch : 8'h00;
      word.ends_arg    = ends;
      word.arg_index   = (has || ends) ? idx : 4'd0;
      word.string_done = done;
      word.arg_total   = done ? args_closed : 4'd0;

      if (done) begin
         strings_done++;
         if (args_closed == TB_MAX_ARGS) strings_at_limit++;
         parse_state  = MODE_BETWEEN;
         quote_single = 1'b0;
         args_closed  = 4'd0;
      end
      return emit;
   endfunction

   // offer one character, wait for it to be taken, then record the expected word
   task automatic send_char(input logic [7:0] c, input logic last);
      rsp_type word;
      if ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_push    <= 1'b1;
      req_in_byte <= c;
      req_is_last <= last;
      forever begin
         @(posedge clock);
         if (!req_full) break;
         input_stalls++;
      end
      chars_sent++;
      if (tokenize_char(c, last, word)) expected_words.push_back(word);
   endtask

   task automatic send_text(input string s, input bit mark_last);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], mark_last && i == s.len() - 1);
   endtask

   task automatic send_line();
      logic [8:0] e;
      while (line_chars.size() != 0) begin
         e = line_chars.pop_front();
         send_char(e[7:0], e[8]);
      end
   endtask

   // result side: check each popped word, idle at random, honor hold-off requests
   always @(posedge clock) begin : result_check
      rsp_type got, want;
      int      hold_left;
      int      holds_seen;
      if (reset) begin
         rsp_pop    <= 1'b0;
         hold_left  = 0;
         holds_seen = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_has_byte, rsp_out_byte, rsp_ends_arg, rsp_arg_index,
                    rsp_string_done, rsp_arg_total};
            if (expected_words.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("Unexpected word at cycle %0d: %p", cycle_count, got);
            end else begin
               want = expected_words.pop_front();
               words_checked++;
               if (got.has_byte !== want.has_byte || got.out_byte !== want.out_byte ||
                   got.ends_arg !== want.ends_arg || got.arg_index !== want.arg_index ||
                   got.string_done !== want.string_done ||
                   got.arg_total !== want.arg_total) begin
                  error_count++;
                  if (error_count <= REPORT_MAX) begin
                     $display("Mismatch on word %0d at cycle %0d", words_checked, cycle_count);
                     $display("  expected has=%0b byte=%02h end=%0b idx=%0d done=%0b total=%0d",
                              want.has_byte, want.out_byte, want.ends_arg, want.arg_index,
                              want.string_done, want.arg_total);
                     $display("  actual   has=%0b byte=%02h end=%0b idx=%0d done=%0b total=%0d",
                              got.has_byte, got.out_byte, got.ends_arg, got.arg_index,
                              got.string_done, got.arg_total);
                  end
               end
            end
         end
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // quote in a plain word, escaped space, quote closing into a new word, empty and open quotes
   task automatic test_quoting();
      send_text("a\"\\  'x'y \"\" \"q", 1'b1);
   endtask

   // escaped quote, trailing backslash, lone backslash as the whole line
   task automatic test_escapes();
      send_text("\\\"x\\", 1'b1);
      send_text("\\", 1'b1);
   endtask

   // byte extremes, zero byte as terminator, empty line
   task automatic test_string_ends();
      send_char(8'hff, 1'b0);
      send_char(8'h01, 1'b0);
      send_char(8'h80, 1'b0);
      send_char(CHAR_NUL, 1'b0);
      send_char(CHAR_NUL, 1'b1);
   endtask

   // every separator kind and more words than the limit
   task automatic test_arg_limit();
      send_text("a\tb\nc\vd\fe\015f g h i j k l", 1'b1);
   endtask

   // result side holds off while plain words keep coming, so the input must stall
   task automatic test_backpressure();
      hold_requests++;
      for (int i = 0; i < 40; i++)
         send_char(8'((i % 7 == 6) ? CHAR_SPACE : 8'h61 + i % 26), i == 39);
   endtask

   // one random command line into line_chars: mostly well-formed, some raw noise
   task automatic build_line();
      int         n_words, kind, len;
      logic [7:0] c, q;
      bit         quoted;
      line_chars.delete();
      if ($urandom_range(99) < 15) begin
         len = $urandom_range(1, 16);
         for (int i = 0; i < len; i++) line_chars.push_back({1'b0, 8'($urandom_range(0, 255))});
         line_chars[$][8] = 1'($urandom_range(1));
         return;
      end
      n_words = ($urandom_range(99) < 15) ? $urandom_range(11, 14) : $urandom_range(1, 6);
      if ($urandom_range(3) == 0) line_chars.push_back({1'b0, CHAR_SPACE});
      for (int w = 0; w < n_words; w++) begin
         kind   = $urandom_range(99);
         quoted = 1'b0;
         if (kind < 50) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               kind = $urandom_range(99);
               if (kind < 15) begin
                  line_chars.push_back({1'b0, CHAR_BSLASH});
                  line_chars.push_back({1'b0, 8'($urandom_range(1, 255))});
               end else if (i > 0 && kind < 25) begin
                  line_chars.push_back({1'b0, kind[0] ? CHAR_SQUOTE : CHAR_DQUOTE});
               end else begin
                  do c = 8'($urandom_range(1, 255));
                  while (is_blank(c) || c == CHAR_SQUOTE || c == CHAR_DQUOTE || c == CHAR_BSLASH);
                  line_chars.push_back({1'b0, c});
               end
            end
         end else if (kind < 90) begin
            quoted = 1'b1;
            q = $urandom_range(1) ? CHAR_SQUOTE : CHAR_DQUOTE;
            line_chars.push_back({1'b0, q});
            len = $urandom_range(0, 5);
            for (int i = 0; i < len; i++) begin
               do c = 8'($urandom_range(1, 255)); while (c == q);
               line_chars.push_back({1'b0, c});
            end
            // leave the last quote open now and then
            if (!(w == n_words - 1 && $urandom_range(3) == 0)) line_chars.push_back({1'b0, q});
         end else begin
            line_chars.push_back({1'b0, CHAR_BSLASH});
         end
         if (w != n_words - 1 && !(quoted && $urandom_range(4) == 0)) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
               kind = $urandom_range(5);
               line_chars.push_back({1'b0, kind == 5 ? CHAR_SPACE : CHAR_TAB + 8'(kind)});
            end
         end
      end
      kind = $urandom_range(99);
      if (kind < 50) line_chars[$][8] = 1'b1;
      else if (kind < 80) line_chars.push_back({1'($urandom_range(1)), CHAR_NUL});
      else line_chars.push_back({1'b1, CHAR_SPACE});
   endtask

   // random lines with a stretch of zero idling in the middle
   task automatic test_random_lines();
      int first_char;
      first_char = chars_sent;
      while (chars_sent - first_char < RANDOM_CHARS) begin
         idle_pct = (chars_sent - first_char >= 400 && chars_sent - first_char < 700) ?
                    0 : IDLE_PCT;
         build_line();
         send_line();
      end
      idle_pct = IDLE_PCT;
      // close whatever a noise line left open
      send_char(CHAR_NUL, 1'b1);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_quoting();
      test_escapes();
      test_string_ends();
      test_arg_limit();
      test_backpressure();
      test_random_lines();

      req_push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d characters in %0d command lines (%0d hit the argument limit);",
               chars_sent, strings_done, strings_at_limit);
      $display("checked %0d result words, input held off for %0d cycles, %0d mismatches.",
               words_checked, input_stalls, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/sat_pkg.sv
hw/rtl/sat_fifo.sv
hw/rtl/sat_front.sv
hw/rtl/sat_back.sv
hw/rtl/shell_argument_tokenizer.sv
hw/rtl/sat_checker.sv
tb/shell_argument_tokenizer_test.sv
